@@ rtl/core/dmwbc_pkg.sv @@
`default_nettype none

package dmwbc_pkg;

    // default geometry
    localparam int unsigned CACHE_LINES_DEF  = 32;
    localparam int unsigned MEMORY_WORDS_DEF = 65536;

    // field widths
    localparam int unsigned DATA_W = 16;
    localparam int unsigned AIN_W  = 16;
    localparam int unsigned CNT_W  = 32;
    localparam int unsigned OP_W   = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_READ    = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE   = 2'd1;
    localparam logic [OP_W-1:0] OP_PRELOAD = 2'd2;

    // controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADDR,
        ST_IDXMUL,
        ST_IDX,
        ST_LOOK,
        ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clear;
        logic load;
        logic addr_sub;
        logic idx_mul;
        logic idx_sub;
        logic lookup;
        logic commit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

@@ rtl/core/dmwbc_ctrl.sv @@
`default_nettype none

module dmwbc_ctrl
    import dmwbc_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      i_in_valid,
    output logic     o_in_ready,
    input  t_status  i_status,
    output t_cmd     o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_status.clear_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_ADDR;
            end
            ST_ADDR:   n_state = ST_IDXMUL;
            ST_IDXMUL: n_state = ST_IDX;
            ST_IDX:    n_state = ST_LOOK;
            ST_LOOK:   n_state = ST_DONE;
            ST_DONE: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default:   n_state = ST_CLEAR;
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_CLEAR:  o_cmd.clear = 1'b1;
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_ADDR:   o_cmd.addr_sub = 1'b1;
            ST_IDXMUL: o_cmd.idx_mul  = 1'b1;
            ST_IDX:    o_cmd.idx_sub  = 1'b1;
            ST_LOOK:   o_cmd.lookup   = 1'b1;
            ST_DONE:   o_cmd.commit   = i_status.out_free;
            default:   o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/dmwbc_dp.sv @@
`default_nettype none

module dmwbc_dp
    import dmwbc_pkg::*;
#(
    parameter int unsigned CACHE_LINES  = CACHE_LINES_DEF,
    parameter int unsigned MEMORY_WORDS = MEMORY_WORDS_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  wire [OP_W-1:0]     i_operation,
    input  wire [AIN_W-1:0]    i_address,
    input  wire [DATA_W-1:0]   i_write_data,
    input  wire                i_out_ready,
    output logic               o_out_valid,
    output logic [DATA_W-1:0]  o_read_data,
    output logic               o_hit,
    output logic               o_wrote_back,
    output logic [CNT_W-1:0]   o_main_read_count,
    output logic [CNT_W-1:0]   o_main_write_count,
    output logic [CNT_W-1:0]   o_hit_count,
    output logic [CNT_W-1:0]   o_miss_count
);

    localparam int unsigned AW    = $clog2(MEMORY_WORDS);
    localparam int unsigned IW    = $clog2(CACHE_LINES);
    localparam int unsigned SWEEP = (MEMORY_WORDS > CACHE_LINES) ? MEMORY_WORDS : CACHE_LINES;
    localparam int unsigned CW    = $clog2(SWEEP);
    localparam int unsigned PW    = AIN_W + 32;
    // reciprocals scaled by 2^32, rounded up: exact quotient for 16-bit dividends
    localparam longint unsigned RA_L = ((64'd1 << 32) + MEMORY_WORDS - 1) / MEMORY_WORDS;
    localparam longint unsigned RI_L = ((64'd1 << 32) + CACHE_LINES - 1) / CACHE_LINES;
    localparam logic [31:0] RA = 32'(RA_L);
    localparam logic [31:0] RI = 32'(RI_L);
    localparam logic [AW-1:0] TOP_ADDR = AW'(MEMORY_WORDS - 1);

    typedef struct packed {
        logic              dirty;
        logic [AW-1:0]     tag;
        logic [DATA_W-1:0] word;
    } t_line;

    // storage
    t_line             line_mem [CACHE_LINES];
    logic [DATA_W-1:0] main_mem [MEMORY_WORDS];

    // clearing sweep
    logic [CW-1:0] r_clr;
    logic [AW-1:0] r_clr_tag;

    // item registers
    logic [OP_W-1:0]   r_op;
    logic [AIN_W-1:0]  r_ain;
    logic [DATA_W-1:0] r_wdata;
    logic [PW-1:0]     r_prod_a;
    logic [AW-1:0]     r_addr;
    logic [PW-1:0]     r_prod_i;
    logic [IW-1:0]     r_idx;
    t_line             r_line_q;
    logic [DATA_W-1:0] r_main_q;

    // counters and output word
    logic [CNT_W-1:0]  r_main_rd;
    logic [CNT_W-1:0]  r_main_wr;
    logic [CNT_W-1:0]  r_hits;
    logic [CNT_W-1:0]  r_misses;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_rdata;
    logic              r_out_hit;
    logic              r_out_wb;

    // address reduction helpers
    logic [AW-1:0]     inv_addr;
    logic [AIN_W-1:0]  q_a;
    logic [AIN_W-1:0]  q_i;
    logic              clr_line;
    logic              clr_main;

    // decision signals
    logic              is_rd;
    logic              is_wr;
    logic              is_pl;
    logic              tag_hit;
    logic              wb;
    logic              line_we;
    t_line             line_wd;
    logic              main_we;
    logic [AW-1:0]     main_wa;
    logic [DATA_W-1:0] main_wd;
    logic [DATA_W-1:0] rdata;

    assign inv_addr = TOP_ADDR - r_addr;
    assign q_a      = r_prod_a[PW-1:32];
    assign q_i      = r_prod_i[PW-1:32];
    assign clr_line = i_cmd.clear && (32'(r_clr) < 32'(CACHE_LINES));
    assign clr_main = i_cmd.clear && (32'(r_clr) < 32'(MEMORY_WORDS));

    assign o_status.clear_last = (r_clr == CW'(SWEEP - 1));
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    // sweep counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= '0;
            r_clr_tag <= TOP_ADDR;
        end else if (i_cmd.clear) begin
            r_clr     <= r_clr + 1'b1;
            r_clr_tag <= (r_clr_tag == '0) ? TOP_ADDR : r_clr_tag - 1'b1;
        end
    end

    // capture and index arithmetic
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_operation;
            r_ain    <= i_address;
            r_wdata  <= i_write_data;
            r_prod_a <= PW'(i_address) * PW'(RA);
        end
        if (i_cmd.addr_sub) begin
            r_addr <= AW'(32'(r_ain) - 32'(q_a) * 32'(MEMORY_WORDS));
        end
        if (i_cmd.idx_mul) begin
            r_prod_i <= PW'(inv_addr) * PW'(RI);
        end
        if (i_cmd.idx_sub) begin
            r_idx <= IW'(32'(inv_addr) - 32'(q_i) * 32'(CACHE_LINES));
        end
    end

    // decision
    always_comb begin
        is_rd   = (r_op == OP_READ);
        is_wr   = (r_op == OP_WRITE);
        is_pl   = (r_op == OP_PRELOAD);
        tag_hit = (r_line_q.tag == r_addr);
        wb      = (is_rd || is_wr) && !tag_hit && r_line_q.dirty;
        rdata   = '0;
        line_we = 1'b0;
        line_wd = r_line_q;
        main_we = 1'b0;
        main_wa = r_addr;
        main_wd = r_wdata;
        if (is_rd) begin
            if (tag_hit) begin
                rdata = r_line_q.word;
            end else begin
                rdata   = r_main_q;
                line_we = 1'b1;
                line_wd = '{dirty: 1'b0, tag: r_addr, word: r_main_q};
            end
        end else if (is_wr) begin
            if (!tag_hit || (r_line_q.word != r_wdata)) begin
                line_we = 1'b1;
                line_wd = '{dirty: 1'b1, tag: r_addr, word: r_wdata};
            end
        end else if (is_pl) begin
            main_we = 1'b1;
        end
        // victim write-back takes the single main store write port
        if (wb) begin
            main_we = 1'b1;
            main_wa = r_line_q.tag;
            main_wd = r_line_q.word;
        end
    end

    // line store
    always_ff @(posedge i_clk) begin
        if (clr_line) begin
            line_mem[r_clr[IW-1:0]] <= '{dirty: 1'b1, tag: r_clr_tag, word: '0};
        end else if (i_cmd.commit && line_we) begin
            line_mem[r_idx] <= line_wd;
        end
        if (i_cmd.lookup) begin
            r_line_q <= line_mem[r_idx];
        end
    end

    // main store
    always_ff @(posedge i_clk) begin
        if (clr_main) begin
            main_mem[r_clr[AW-1:0]] <= '0;
        end else if (i_cmd.commit && main_we) begin
            main_mem[main_wa] <= main_wd;
        end
        if (i_cmd.lookup) begin
            r_main_q <= main_mem[r_addr];
        end
    end

    // statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_rd <= '0;
            r_main_wr <= '0;
            r_hits    <= '0;
            r_misses  <= '0;
        end else if (i_cmd.commit) begin
            if (is_rd && tag_hit) r_hits <= r_hits + 1'b1;
            if (is_rd && !tag_hit) begin
                r_misses  <= r_misses + 1'b1;
                r_main_rd <= r_main_rd + 1'b1;
            end
            if (wb) r_main_wr <= r_main_wr + 1'b1;
        end
    end

    // output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_rdata <= rdata;
            r_out_hit   <= (is_rd || is_wr) && tag_hit;
            r_out_wb    <= wb;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_read_data        = r_out_rdata;
    assign o_hit              = r_out_hit;
    assign o_wrote_back       = r_out_wb;
    assign o_main_read_count  = r_main_rd;
    assign o_main_write_count = r_main_wr;
    assign o_hit_count        = r_hits;
    assign o_miss_count       = r_misses;

endmodule

`default_nettype wire

@@ rtl/core/direct_mapped_write_back_cache.sv @@
// A word is captured, then stepped through address wrap, two index reduction
// steps, memory lookup and update before its result word is presented; a new
// word is taken only once the previous word's update is done, and output
// stalls hold the update step.
// Reset: synchronous, active low; then a clearing sweep over
// max(MEMORY_WORDS, CACHE_LINES) entries runs before the first word is taken.
`default_nettype none

module direct_mapped_write_back_cache
    import dmwbc_pkg::*;
#(
    parameter int unsigned CACHE_LINES  = CACHE_LINES_DEF,
    parameter int unsigned MEMORY_WORDS = MEMORY_WORDS_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [31:0]  s_axis_tdata,   // address[15:0], write_data[31:16]
    input  wire  [1:0]   s_axis_tuser,   // operation[1:0]
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [151:0] m_axis_tdata    // read_data[15:0], hit[16], wrote_back[17],
                                         // main_read_count[49:18],
                                         // main_write_count[81:50],
                                         // hit_count[113:82], miss_count[145:114],
                                         // zero pad[151:146]
);

    t_cmd    cmd;
    t_status status;

    logic [DATA_W-1:0] read_data;
    logic              hit;
    logic              wrote_back;
    logic [CNT_W-1:0]  main_read_count;
    logic [CNT_W-1:0]  main_write_count;
    logic [CNT_W-1:0]  hit_count;
    logic [CNT_W-1:0]  miss_count;

    dmwbc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    dmwbc_dp #(
        .CACHE_LINES  (CACHE_LINES),
        .MEMORY_WORDS (MEMORY_WORDS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_operation        (s_axis_tuser),
        .i_address          (s_axis_tdata[15:0]),
        .i_write_data       (s_axis_tdata[31:16]),
        .i_out_ready        (m_axis_tready),
        .o_out_valid        (m_axis_tvalid),
        .o_read_data        (read_data),
        .o_hit              (hit),
        .o_wrote_back       (wrote_back),
        .o_main_read_count  (main_read_count),
        .o_main_write_count (main_write_count),
        .o_hit_count        (hit_count),
        .o_miss_count       (miss_count)
    );

    // pack result word
    assign m_axis_tdata = {6'b0, miss_count, hit_count, main_write_count,
                           main_read_count, wrote_back, hit, read_data};

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`default_nettype none

module tb_top;
    import dmwbc_pkg::*;

    // op code the block must ignore
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int unsigned LINES        = CACHE_LINES_DEF;
    localparam int unsigned WORDS        = MEMORY_WORDS_DEF;
    localparam int unsigned RANDOM_WORDS = 1850;
    // idle cycles allowed with no word moving; covers the clearing sweep
    localparam int unsigned STALL_LIMIT  = 300000;
    localparam int unsigned DRAIN_CYCLES = 12;

    // result word, lowest field last
    typedef struct packed {
        logic [5:0]       pad;
        logic [CNT_W-1:0] miss_count;
        logic [CNT_W-1:0] hit_count;
        logic [CNT_W-1:0] main_write_count;
        logic [CNT_W-1:0] main_read_count;
        logic             wrote_back;
        logic             hit;
        logic [DATA_W-1:0] read_data;
    } t_cache_result;

    // mirror of the cache and main store; predicts one result word per access
    class cache_tracker;
        bit [DATA_W-1:0] line_word [LINES];
        bit [AIN_W-1:0]  line_tag  [LINES];
        bit              line_dirty[LINES];
        bit [DATA_W-1:0] main_store[WORDS];
        bit [CNT_W-1:0]  main_reads, main_writes, read_hits, read_misses;
        t_cache_result   pending_results[$];
        int unsigned     mismatches;

        function new();
            for (int i = 0; i < LINES; i++) begin
                line_word[i]  = '0;
                line_tag[i]   = AIN_W'((WORDS - 1) - (i % WORDS));
                line_dirty[i] = 1'b1;
            end
            foreach (main_store[i]) main_store[i] = '0;
            main_reads  = '0;
            main_writes = '0;
            read_hits   = '0;
            read_misses = '0;
            mismatches  = 0;
        endfunction

        function int unsigned line_index(bit [AIN_W-1:0] addr);
            return ((WORDS - 1) - int'(addr) % WORDS) % LINES;
        endfunction

        // push victim to main store when dirty
        function bit evict(int unsigned idx);
            if (!line_dirty[idx]) return 1'b0;
            main_store[int'(line_tag[idx]) % WORDS] = line_word[idx];
            main_writes++;
            return 1'b1;
        endfunction

        function void apply_access(logic [OP_W-1:0] op, logic [AIN_W-1:0] addr,
                                   logic [DATA_W-1:0] data);
            int unsigned   idx;
            t_cache_result res;
            idx = line_index(addr);
            res = '0;
            case (op)
                OP_READ: begin
                    if (line_tag[idx] == addr) begin
                        res.hit = 1'b1;
                        read_hits++;
                        res.read_data = line_word[idx];
                    end else begin
                        read_misses++;
                        res.read_data = main_store[addr];
                        main_reads++;
                        res.wrote_back = evict(idx);
                        line_word[idx]  = res.read_data;
                        line_tag[idx]   = addr;
                        line_dirty[idx] = 1'b0;
                    end
                end
                OP_WRITE: begin
                    if (line_tag[idx] == addr) begin
                        res.hit = 1'b1;
                        if (line_word[idx] != data) begin
                            line_word[idx]  = data;
                            line_dirty[idx] = 1'b1;
                        end
                    end else begin
                        res.wrote_back = evict(idx);
                        line_word[idx]  = data;
                        line_tag[idx]   = addr;
                        line_dirty[idx] = 1'b1;
                    end
                end
                OP_PRELOAD: main_store[addr] = data;
                default: ;
            endcase
            res.main_read_count  = main_reads;
            res.main_write_count = main_writes;
            res.hit_count        = read_hits;
            res.miss_count       = read_misses;
            pending_results.push_back(res);
        endfunction

        function void compare_result(logic [151:0] word);
            t_cache_result got, exp;
            got = word;
            if (pending_results.size() == 0) begin
                $error("result word with no access outstanding: %h", word);
                mismatches++;
                return;
            end
            exp = pending_results.pop_front();
            if (got.read_data !== exp.read_data) begin
                $error("read_data exp %h got %h", exp.read_data, got.read_data);
                mismatches++;
            end
            if (got.hit !== exp.hit) begin
                $error("hit exp %0d got %0d", exp.hit, got.hit);
                mismatches++;
            end
            if (got.wrote_back !== exp.wrote_back) begin
                $error("wrote_back exp %0d got %0d", exp.wrote_back, got.wrote_back);
                mismatches++;
            end
            if (got.main_read_count !== exp.main_read_count) begin
                $error("main_read_count exp %0d got %0d",
                       exp.main_read_count, got.main_read_count);
                mismatches++;
            end
            if (got.main_write_count !== exp.main_write_count) begin
                $error("main_write_count exp %0d got %0d",
                       exp.main_write_count, got.main_write_count);
                mismatches++;
            end
            if (got.hit_count !== exp.hit_count) begin
                $error("hit_count exp %0d got %0d", exp.hit_count, got.hit_count);
                mismatches++;
            end
            if (got.miss_count !== exp.miss_count) begin
                $error("miss_count exp %0d got %0d", exp.miss_count, got.miss_count);
                mismatches++;
            end
        endfunction
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata;   // address[15:0], write_data[31:16]
    logic [1:0]   s_axis_tuser;   // operation[1:0]
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [151:0] m_axis_tdata;   // read_data, hit, wrote_back, four counters, pad

    cache_tracker tracker;
    bit           no_idle;        // stretches with no gaps on either side
    int unsigned  quiet_cycles;
    logic [AIN_W-1:0] recent_addr[8];

    direct_mapped_write_back_cache DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 12-unit clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // drive one access word; holds tvalid until accepted
    task automatic send_access(logic [OP_W-1:0] op, logic [AIN_W-1:0] addr,
                               logic [DATA_W-1:0] data);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {data, addr};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        recent_addr[$urandom_range(0, 7)] = addr;
    endtask

    // random access biased toward conflicting and reused addresses
    task automatic random_access();
        int unsigned      pick;
        logic [OP_W-1:0]  op;
        logic [AIN_W-1:0] addr;
        logic [DATA_W-1:0] data;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            addr = $urandom_range(0, 1) ? AIN_W'($urandom_range(0, 63))
                                        : AIN_W'($urandom_range(16'hFFC0, 16'hFFFF));
        end else if (pick < 60) begin
            addr = recent_addr[$urandom_range(0, 7)];
        end else begin
            addr = AIN_W'($urandom_range(0, 65535));
        end
        pick = $urandom_range(0, 99);
        if (pick < 45)      op = OP_READ;
        else if (pick < 85) op = OP_WRITE;
        else if (pick < 98) op = OP_PRELOAD;
        else                op = OP_UNUSED;
        pick = $urandom_range(0, 99);
        if (pick < 15)      data = tracker.line_word[tracker.line_index(addr)];
        else if (pick < 20) data = '0;
        else if (pick < 25) data = '1;
        else                data = DATA_W'($urandom_range(0, 65535));
        send_access(op, addr, data);
    endtask

    // result side: random stalls between words
    initial begin
        int unsigned stall;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 4);
            @(negedge i_clk);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    // check results, record accepted accesses, watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                tracker.compare_result(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                tracker.apply_access(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[31:16]);
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        tracker       = new();
        no_idle       = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_READ;
        foreach (recent_addr[i]) recent_addr[i] = 16'hFFE0 + AIN_W'(i);
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset contents, hits, misses, dirty and clean victims
        send_access(OP_READ,    16'hFFFF, 16'h0000);  // reset tag hit
        send_access(OP_READ,    16'hFFE0, 16'h0000);  // last line hit
        send_access(OP_WRITE,   16'hFFFE, 16'h0000);  // write hit, same value
        send_access(OP_WRITE,   16'hFFFE, 16'hFFFF);  // write hit, new value
        send_access(OP_READ,    16'hFFFE, 16'h0000);
        send_access(OP_PRELOAD, 16'h0001, 16'hA5A5);
        send_access(OP_READ,    16'h0001, 16'h0000);  // miss, dirty victim
        send_access(OP_READ,    16'hFFE1, 16'h0000);  // miss, clean victim
        send_access(OP_PRELOAD, 16'hFFE1, 16'h1234);  // cached copy goes stale
        send_access(OP_READ,    16'hFFE1, 16'h0000);  // hit returns stale word
        send_access(OP_WRITE,   16'h0002, 16'hFFFF);  // write miss, dirty victim
        send_access(OP_WRITE,   16'h0022, 16'h0000);  // write miss, dirty victim
        send_access(OP_READ,    16'h0002, 16'h0000);
        send_access(OP_WRITE,   16'h0022, 16'h5A5A);  // write miss, clean victim
        send_access(OP_UNUSED,  16'hFFFF, 16'hFFFF);  // ignored op
        send_access(OP_PRELOAD, 16'hFFFF, 16'hFFFF);
        send_access(OP_READ,    16'h0000, 16'h0000);
        send_access(OP_READ,    16'hFFE0, 16'h0000);
        send_access(OP_WRITE,   16'hFFFF, 16'h8001);
        send_access(OP_READ,    16'h001F, 16'h0000);  // evicts dirty 0xFFFF
        send_access(OP_READ,    16'hFFFF, 16'h0000);  // write-back beat preload
        send_access(OP_UNUSED,  16'h0000, 16'h0000);

        // random part, with idle-free stretches now and then
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 150 == 0) no_idle = ($urandom_range(0, 3) == 0);
            random_access();
        end
        no_idle = 1'b0;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;

        // drain, then allow the pipeline to settle
        while (tracker.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
